[src/port_range_coalescing_table_top_macros.svh]
// Assertion helpers shared by the checking code of the range table.
`ifndef PORT_RANGE_COALESCING_TABLE_TOP_MACROS_SVH
`define PORT_RANGE_COALESCING_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[src/prtc_pkg.sv]
// ----------------------------------------------------------------------------
// prtc_pkg
// Shared sizes, codes and types of the port range coalescing table.
// ----------------------------------------------------------------------------
package prtc_pkg;

	localparam int MAX_RANGES = 32;
	localparam int PORT_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 7;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXTEND  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REPORT  = 3'd4;

	typedef struct packed {
		logic                 mark;
		logic [PORT_BITS-1:0] lo;
		logic [PORT_BITS-1:0] hi;
	} entry_t;

	typedef struct packed {
		logic below;
		logic covered;
		logic ext_hi;
		logic ext_lo;
	} cmp_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [PORT_BITS-1:0] range_low;
		logic [PORT_BITS-1:0] range_high;
		logic                 range_valid;
		logic [COUNT_W-1:0]   range_count;
		logic                 last;
	} res_t;

endpackage

[src/prtc_cmd_if.sv]
// ----------------------------------------------------------------------------
// prtc_cmd_if
// Command channel: insert a port or report changed ranges.
// ----------------------------------------------------------------------------
interface prtc_cmd_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [prtc_pkg::PORT_BITS-1:0] port;

	modport source (output valid, output action, output port, input ready);
	modport sink (input valid, input action, input port, output ready);
endinterface

[src/prtc_rsp_if.sv]
// ----------------------------------------------------------------------------
// prtc_rsp_if
// Result channel: insert outcome or one reported range.
// ----------------------------------------------------------------------------
interface prtc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [prtc_pkg::STATUS_W-1:0]  status;
	logic [prtc_pkg::PORT_BITS-1:0] range_low;
	logic [prtc_pkg::PORT_BITS-1:0] range_high;
	logic                           range_valid;
	logic [prtc_pkg::COUNT_W-1:0]   range_count;
	logic                           last;

	modport source (output valid, output status, output range_low, output range_high,
		output range_valid, output range_count, output last, input ready);
	modport sink (input valid, input status, input range_low, input range_high,
		input range_valid, input range_count, input last, output ready);
endinterface

[src/prtc_cmp.sv]
// ----------------------------------------------------------------------------
// prtc_cmp
// Shared compare unit: places a port against one stored range.
// ----------------------------------------------------------------------------
module prtc_cmp (
	input  logic [prtc_pkg::PORT_BITS-1:0] port,
	input  prtc_pkg::entry_t               ent,
	output prtc_pkg::cmp_t                 flags
);

	localparam int PW = prtc_pkg::PORT_BITS;

	logic [PW:0] port_x;
	logic [PW:0] port_p1;
	logic [PW:0] hi_p1;

	// one extra bit keeps the +1 from wrapping past the top port
	always_comb begin
		port_x        = {1'b0, port};
		port_p1       = port_x + (PW + 1)'(1);
		hi_p1         = {1'b0, ent.hi} + (PW + 1)'(1);
		flags.below   = hi_p1 < port_x;
		flags.covered = (port >= ent.lo) && (port <= ent.hi);
		flags.ext_hi  = port_x == hi_p1;
		flags.ext_lo  = port_p1 == {1'b0, ent.lo};
	end

endmodule

[src/prtc_obuf.sv]
// ----------------------------------------------------------------------------
// prtc_obuf
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module prtc_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_vld,
	input  prtc_pkg::res_t      push_res,
	output logic                push_rdy,
	prtc_rsp_if.source          rsp
);

	logic           valid_q;
	prtc_pkg::res_t data_q;

	assign push_rdy = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_rdy) begin
			valid_q <= push_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (push_rdy && push_vld) begin
			data_q <= push_res;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.status      = data_q.status;
	assign rsp.range_low   = data_q.range_low;
	assign rsp.range_high  = data_q.range_high;
	assign rsp.range_valid = data_q.range_valid;
	assign rsp.range_count = data_q.range_count;
	assign rsp.last        = data_q.last;

endmodule

[src/prtc_seq.sv]
// ----------------------------------------------------------------------------
// prtc_seq
// Sequencer, range memory: scans, shifts, reports one entry a cycle unless stalled.
// ----------------------------------------------------------------------------
`include "port_range_coalescing_table_top_macros.svh"

module prtc_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	prtc_cmd_if.sink                       cmd,
	output logic [prtc_pkg::PORT_BITS-1:0] cmp_port,
	output prtc_pkg::entry_t               cmp_ent,
	input  prtc_pkg::cmp_t                 cmp_flags,
	output logic                           res_vld,
	output prtc_pkg::res_t                 res,
	input  logic                           res_rdy
);

	localparam int CW = prtc_pkg::CNT_W;
	localparam int IW = prtc_pkg::IDX_W;
	localparam int PW = prtc_pkg::PORT_BITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_EXTHI = 3'd2;
	localparam logic [2:0] S_SHDN  = 3'd3;
	localparam logic [2:0] S_SHUP  = 3'd4;
	localparam logic [2:0] S_NEWWR = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;
	localparam logic [2:0] S_RPT   = 3'd7;

	logic [2:0]                  state_q, state_d;
	logic [CW-1:0]               idx_q, idx_d;
	logic [CW-1:0]               used_q, used_d;
	logic                        pend_vld_q, pend_vld_d;
	logic [PW-1:0]               port_q, port_d;
	logic [CW-1:0]               ins_q, ins_d;
	logic [PW-1:0]               lo_q, lo_d;
	logic [prtc_pkg::STATUS_W-1:0] status_q, status_d;
	logic [PW-1:0]               pend_lo_q, pend_lo_d;
	logic [PW-1:0]               pend_hi_q, pend_hi_d;

	prtc_pkg::entry_t entries_q [prtc_pkg::MAX_RANGES];
	prtc_pkg::entry_t rd_q;
	logic [CW-1:0]    rd_idx;
	logic             we;
	logic [CW-1:0]    wr_idx;
	prtc_pkg::entry_t wr_data;
	logic             full;

	// rd_q belongs to idx_q in scan and report, to the entry below/above it in SHUP/SHDN
	always_ff @(posedge clk) begin
		if (we) begin
			entries_q[wr_idx[IW-1:0]] <= wr_data;
		end
		rd_q <= entries_q[rd_idx[IW-1:0]];
	end

	assign cmp_port  = port_q;
	assign cmp_ent   = rd_q;
	assign cmd.ready = state_q == S_IDLE;
	assign full      = used_q == CW'(prtc_pkg::MAX_RANGES);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		used_d     = used_q;
		pend_vld_d = pend_vld_q;
		port_d     = port_q;
		ins_d      = ins_q;
		lo_d       = lo_q;
		status_d   = status_q;
		pend_lo_d  = pend_lo_q;
		pend_hi_d  = pend_hi_q;
		rd_idx     = idx_q;
		we         = 1'b0;
		wr_idx     = idx_q;
		wr_data    = '{mark: 1'b1, lo: port_q, hi: port_q};
		res_vld    = 1'b0;
		res        = '{status: status_q, range_low: '0, range_high: '0,
			range_valid: 1'b0, range_count: prtc_pkg::COUNT_W'(used_q), last: 1'b1};

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					port_d     = cmd.port;
					idx_d      = '0;
					rd_idx     = '0;
					pend_vld_d = 1'b0;
					state_d    = (cmd.action == prtc_pkg::ACT_REPORT) ? S_RPT : S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (idx_q == used_q || !(cmp_flags.below || cmp_flags.covered ||
						cmp_flags.ext_hi || cmp_flags.ext_lo)) begin
					// new range goes at idx_q
					ins_d = idx_q;
					priority if (full) begin
						status_d = prtc_pkg::ST_FULL;
						state_d  = S_RESP;
					end else if (idx_q == used_q) begin
						state_d = S_NEWWR;
					end else begin
						idx_d   = used_q;
						rd_idx  = used_q - CW'(1);
						state_d = S_SHUP;
					end
				end else if (cmp_flags.below) begin
					idx_d  = idx_q + CW'(1);
					rd_idx = idx_q + CW'(1);
				end else if (cmp_flags.covered) begin
					status_d = prtc_pkg::ST_PRESENT;
					state_d  = S_RESP;
				end else if (cmp_flags.ext_hi) begin
					ins_d   = idx_q;
					lo_d    = rd_q.lo;
					idx_d   = idx_q + CW'(1);
					rd_idx  = idx_q + CW'(1);
					state_d = S_EXTHI;
				end else begin
					we       = 1'b1;
					wr_idx   = idx_q;
					wr_data  = '{mark: 1'b1, lo: port_q, hi: rd_q.hi};
					status_d = prtc_pkg::ST_EXTEND;
					state_d  = S_RESP;
				end
			end
			S_EXTHI: begin
				// rd_q holds the upper neighbor of the extended range
				we       = 1'b1;
				wr_idx   = ins_q;
				status_d = prtc_pkg::ST_EXTEND;
				if (idx_q < used_q && cmp_flags.ext_lo) begin
					wr_data = '{mark: 1'b1, lo: lo_q, hi: rd_q.hi};
					if (idx_q + CW'(1) == used_q) begin
						used_d  = used_q - CW'(1);
						state_d = S_RESP;
					end else begin
						rd_idx  = idx_q + CW'(1);
						state_d = S_SHDN;
					end
				end else begin
					wr_data = '{mark: 1'b1, lo: lo_q, hi: port_q};
					state_d = S_RESP;
				end
			end
			S_SHDN: begin
				// close the gap left by the absorbed neighbor
				we      = 1'b1;
				wr_idx  = idx_q;
				wr_data = rd_q;
				if (idx_q + CW'(2) == used_q) begin
					used_d  = used_q - CW'(1);
					state_d = S_RESP;
				end else begin
					idx_d  = idx_q + CW'(1);
					rd_idx = idx_q + CW'(2);
				end
			end
			S_SHUP: begin
				// open a slot at ins_q, moving entries up from the top
				we      = 1'b1;
				wr_idx  = idx_q;
				wr_data = rd_q;
				idx_d   = idx_q - CW'(1);
				rd_idx  = idx_q - CW'(2);
				if (idx_q - CW'(1) == ins_q) begin
					state_d = S_NEWWR;
				end
			end
			S_NEWWR: begin
				we       = 1'b1;
				wr_idx   = ins_q;
				used_d   = used_q + CW'(1);
				status_d = prtc_pkg::ST_NEW;
				state_d  = S_RESP;
			end
			S_RESP: begin
				res_vld = 1'b1;
				if (res_rdy) begin
					state_d = S_IDLE;
				end
			end
			S_RPT: begin
				res.status = prtc_pkg::ST_REPORT;
				if (idx_q == used_q) begin
					// flush the held range as the final beat, or the empty beat
					res_vld          = 1'b1;
					res.range_valid  = pend_vld_q;
					res.range_low    = pend_vld_q ? pend_lo_q : '0;
					res.range_high   = pend_vld_q ? pend_hi_q : '0;
					if (res_rdy) begin
						state_d = S_IDLE;
					end
				end else if (rd_q.mark) begin
					res_vld          = pend_vld_q;
					res.range_valid  = 1'b1;
					res.range_low    = pend_lo_q;
					res.range_high   = pend_hi_q;
					res.last         = 1'b0;
					if (!pend_vld_q || res_rdy) begin
						we         = 1'b1;
						wr_idx     = idx_q;
						wr_data    = '{mark: 1'b0, lo: rd_q.lo, hi: rd_q.hi};
						pend_vld_d = 1'b1;
						pend_lo_d  = rd_q.lo;
						pend_hi_d  = rd_q.hi;
						idx_d      = idx_q + CW'(1);
						rd_idx     = idx_q + CW'(1);
					end
				end else begin
					idx_d  = idx_q + CW'(1);
					rd_idx = idx_q + CW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			used_q     <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			used_q     <= used_d;
			pend_vld_q <= pend_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		port_q    <= port_d;
		ins_q     <= ins_d;
		lo_q      <= lo_d;
		status_q  <= status_d;
		pend_lo_q <= pend_lo_d;
		pend_hi_q <= pend_hi_d;
	end

	`PRTC_ASSERT_NOW(a_used_bound, clk, arst_n, 1'b1,
		used_q <= CW'(prtc_pkg::MAX_RANGES))
	`PRTC_ASSERT_NOW(a_write_in_table, clk, arst_n, we,
		wr_idx < CW'(prtc_pkg::MAX_RANGES) && wr_idx <= used_q)
	`PRTC_ASSERT_NEXT(a_idle_keeps_count, clk, arst_n, state_q == S_IDLE,
		used_q == $past(used_q))
	`PRTC_ASSERT_NEXT(a_report_stall_holds, clk, arst_n,
		state_q == S_RPT && res_vld && !res_rdy, idx_q == $past(idx_q))

endmodule

[src/port_range_coalescing_table_top.sv]
// ----------------------------------------------------------------------------
// port_range_coalescing_table_top
// Sorted table of disjoint port ranges with insert/merge and change report.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  cmd      in   action, port
//  rsp      out  status, range_low, range_high, range_valid, range_count, last
//
// One command is taken at a time; cmd.ready is high only while the sequencer
// is idle. The range memory has one read and one write port, so every scan,
// shift or report step works on one table entry. An insert's scan stops at the
// insertion point; its shift moves only the entries at and above it.
// Reset clears the range count; the memory contents need no clearing pass.
module port_range_coalescing_table_top (
	input  logic        clk,
	input  logic        arst_n,
	prtc_cmd_if.sink    cmd,
	prtc_rsp_if.source  rsp
);

	logic [prtc_pkg::PORT_BITS-1:0] cmp_port;
	prtc_pkg::entry_t               cmp_ent;
	prtc_pkg::cmp_t                 cmp_flags;
	logic                           res_vld;
	logic                           res_rdy;
	prtc_pkg::res_t                 res;

	prtc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmp_port  (cmp_port),
		.cmp_ent   (cmp_ent),
		.cmp_flags (cmp_flags),
		.res_vld   (res_vld),
		.res       (res),
		.res_rdy   (res_rdy)
	);

	prtc_cmp u_cmp (
		.port  (cmp_port),
		.ent   (cmp_ent),
		.flags (cmp_flags)
	);

	prtc_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_vld (res_vld),
		.push_res (res),
		.push_rdy (res_rdy),
		.rsp      (rsp)
	);

endmodule

[verif/tb_port_range_coalescing_table_top.sv]
// ----------------------------------------------------------------------------
// tb_port_range_coalescing_table_top
// Self-checking bench for the port range coalescing table. Commands are
// queued by a stimulus process and driven by a clocked driver. Accepted
// commands are replayed on a local copy of the sorted range table to build the
// expected result beats. A clocked monitor checks every result beat field by
// field. Sender gaps, receiver stalls and one long receiver hold-off are
// applied in phases.
// ----------------------------------------------------------------------------
module tb_port_range_coalescing_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	import prtc_pkg::*;

	localparam int HALF_PERIOD      = 5;
	localparam int RESET_CYCLES     = 6;
	localparam int CYCLE_LIMIT      = 600000;
	localparam int SETTLE_CYCLES    = 100;
	localparam int HOLD_CYCLES      = 400;
	localparam int WINDOW           = 80;
	localparam int RANDOM_PER_PHASE = 72;
	localparam int PRESSURE_ITEMS   = 20;
	localparam int PRINT_CAP        = 100;
	localparam int TOP_PORT         = (1 << PORT_BITS) - 1;

	typedef struct packed {
		logic                 action;
		logic [PORT_BITS-1:0] port;
	} cmd_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prtc_cmd_if cmd_bus ();
	prtc_rsp_if rsp_bus ();

	port_range_coalescing_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	always #HALF_PERIOD clk = ~clk;

	// Local copy of the range table
	logic [PORT_BITS-1:0] range_lo [MAX_RANGES];
	logic [PORT_BITS-1:0] range_hi [MAX_RANGES];
	logic                 range_dirty [MAX_RANGES];
	int                   ranges_held = 0;

	cmd_beat_t pending_cmds [$];
	res_t      awaited_results [$];

	int beats_queued = 0;
	int beats_taken = 0;
	int rsp_beats = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_rsp = 1'b0;

	// Apply one accepted command to the local table and queue its result beats.
	function automatic void apply_range_action(logic act, logic [PORT_BITS-1:0] port_in);
		int p;
		int i;
		int j;
		int last_idx;
		bit handled;
		res_t r;
		p = int'(port_in);
		r = '0;
		if (act == ACT_INSERT) begin
			i = 0;
			handled = 1'b0;
			while (i < ranges_held && int'(range_hi[i]) + 1 < p) i++;
			if (i < ranges_held) begin
				if (p >= int'(range_lo[i]) && p <= int'(range_hi[i])) begin
					r.status = ST_PRESENT;
					handled = 1'b1;
				end else if (p == int'(range_hi[i]) + 1) begin
					range_hi[i] = PORT_BITS'(p);
					range_dirty[i] = 1'b1;
					// absorb the upper neighbor when the gap closes
					if (i + 1 < ranges_held && int'(range_lo[i + 1]) == p + 1) begin
						range_hi[i] = range_hi[i + 1];
						for (j = i + 1; j + 1 < ranges_held; j++) begin
							range_lo[j] = range_lo[j + 1];
							range_hi[j] = range_hi[j + 1];
							range_dirty[j] = range_dirty[j + 1];
						end
						ranges_held--;
					end
					r.status = ST_EXTEND;
					handled = 1'b1;
				end else if (p + 1 == int'(range_lo[i])) begin
					range_lo[i] = PORT_BITS'(p);
					range_dirty[i] = 1'b1;
					r.status = ST_EXTEND;
					handled = 1'b1;
				end
			end
			if (!handled) begin
				if (ranges_held >= MAX_RANGES) begin
					r.status = ST_FULL;
				end else begin
					for (j = ranges_held; j > i; j--) begin
						range_lo[j] = range_lo[j - 1];
						range_hi[j] = range_hi[j - 1];
						range_dirty[j] = range_dirty[j - 1];
					end
					range_lo[i] = PORT_BITS'(p);
					range_hi[i] = PORT_BITS'(p);
					range_dirty[i] = 1'b1;
					ranges_held++;
					r.status = ST_NEW;
				end
			end
			r.range_count = COUNT_W'(ranges_held);
			r.last = 1'b1;
			awaited_results.push_back(r);
		end else begin
			last_idx = -1;
			for (i = 0; i < ranges_held; i++) begin
				if (range_dirty[i]) begin
					r.status = ST_REPORT;
					r.range_low = range_lo[i];
					r.range_high = range_hi[i];
					r.range_valid = 1'b1;
					r.range_count = COUNT_W'(ranges_held);
					r.last = 1'b0;
					awaited_results.push_back(r);
					range_dirty[i] = 1'b0;
					last_idx = awaited_results.size() - 1;
				end
			end
			if (last_idx < 0) begin
				r.status = ST_REPORT;
				r.range_count = COUNT_W'(ranges_held);
				r.last = 1'b1;
				awaited_results.push_back(r);
			end else begin
				awaited_results[last_idx].last = 1'b1;
			end
		end
	endfunction

	function automatic cmd_beat_t pick_beat(int base, bit even_only);
		cmd_beat_t b;
		int roll;
		int off;
		roll = $urandom_range(0, 99);
		b.action = (roll < 15) ? ACT_REPORT : ACT_INSERT;
		b.port = PORT_BITS'($urandom);
		// mostly ports from a narrow window so ranges grow, touch and merge
		if (roll >= 20) begin
			off = $urandom_range(0, WINDOW - 1);
			if (even_only) off = off & ~1;
			b.port = PORT_BITS'(base + off);
		end
		return b;
	endfunction

	task automatic queue_cmd(logic act, logic [PORT_BITS-1:0] p);
		cmd_beat_t b;
		b.action = act;
		b.port = p;
		pending_cmds.push_back(b);
		beats_queued++;
	endtask

	task automatic wait_drained();
		while (beats_taken != beats_queued || awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(string field, int got, int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at result beat %0d: %s got %0d want %0d",
				rsp_beats, field, got, want);
	endtask

	// Command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.action <= ACT_INSERT;
			cmd_bus.port <= '0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				apply_range_action(cmd_bus.action, cmd_bus.port);
				beats_taken++;
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					cmd_bus.valid <= 1'b1;
					cmd_bus.action <= pending_cmds[0].action;
					cmd_bus.port <= pending_cmds[0].port;
					void'(pending_cmds.pop_front());
				end else begin
					// idle: scramble the payload, it must be ignored
					cmd_bus.valid <= 1'b0;
					cmd_bus.action <= 1'($urandom);
					cmd_bus.port <= PORT_BITS'($urandom);
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("beat with nothing awaited, status", rsp_bus.status, 0);
				end else begin
					want = awaited_results.pop_front();
					if (rsp_bus.status !== want.status)
						report_mismatch("status", rsp_bus.status, want.status);
					if (rsp_bus.range_low !== want.range_low)
						report_mismatch("range_low", rsp_bus.range_low, want.range_low);
					if (rsp_bus.range_high !== want.range_high)
						report_mismatch("range_high", rsp_bus.range_high, want.range_high);
					if (rsp_bus.range_valid !== want.range_valid)
						report_mismatch("range_valid", rsp_bus.range_valid, want.range_valid);
					if (rsp_bus.range_count !== want.range_count)
						report_mismatch("range_count", rsp_bus.range_count, want.range_count);
					if (rsp_bus.last !== want.last)
						report_mismatch("last", rsp_bus.last, want.last);
				end
				rsp_beats++;
			end
			rsp_bus.ready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Long receiver hold-off so the block backs up and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int base;
		cmd_beat_t b;
		cmd_bus.valid = 1'b0;
		cmd_bus.action = ACT_INSERT;
		cmd_bus.port = '0;
		rsp_bus.ready = 1'b0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			range_lo[k] = '0;
			range_hi[k] = '0;
			range_dirty[k] = 1'b0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty report, extremes without wrap, extend both ends, merges
		queue_cmd(ACT_REPORT, 16'hFFFF);
		queue_cmd(ACT_INSERT, 16'hFFFF);
		queue_cmd(ACT_INSERT, 16'h0000);
		queue_cmd(ACT_INSERT, 16'h0000);
		queue_cmd(ACT_INSERT, 16'h0001);
		queue_cmd(ACT_INSERT, 16'hFFFE);
		queue_cmd(ACT_INSERT, 16'hFFFF);
		queue_cmd(ACT_INSERT, 16'd100);
		queue_cmd(ACT_INSERT, 16'd102);
		queue_cmd(ACT_INSERT, 16'd101);
		queue_cmd(ACT_REPORT, 16'h0000);
		queue_cmd(ACT_REPORT, 16'h5555);
		queue_cmd(ACT_INSERT, 16'd3);
		queue_cmd(ACT_INSERT, 16'd2);
		queue_cmd(ACT_INSERT, 16'd99);
		queue_cmd(ACT_INSERT, 16'd101);
		queue_cmd(ACT_REPORT, 16'hAAAA);
		queue_cmd(ACT_INSERT, 16'h5555);
		queue_cmd(ACT_INSERT, 16'hAAAA);
		queue_cmd(ACT_REPORT, 16'h0000);
		wait_drained();

		// Random phases: in each, the first half builds many ranges, the second half merges them
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					base = 0;
				end
				1: begin
					idle_pct = 49;
					stall_pct = 0;
					base = TOP_PORT - WINDOW + 1;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 49;
					base = $urandom_range(0, TOP_PORT - WINDOW + 1);
				end
				default: begin
					idle_pct = 21;
					stall_pct = 21;
					base = $urandom_range(0, TOP_PORT - WINDOW + 1);
				end
			endcase
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				b = pick_beat(base, k < RANDOM_PER_PHASE / 2);
				queue_cmd(b.action, b.port);
			end
			wait_drained();
		end

		// Backpressure: receiver holds off while commands keep coming
		idle_pct = 0;
		stall_pct = 0;
		base = $urandom_range(0, TOP_PORT - WINDOW + 1);
		hold_go = 1'b1;
		for (int k = 0; k < PRESSURE_ITEMS; k++) begin
			b = pick_beat(base, 1'b0);
			queue_cmd(b.action, b.port);
		end
		queue_cmd(ACT_REPORT, 16'h0000);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
